@@ rtl/orq_pkg.sv @@
// ----------------------------------------------------------------------------
// orq_pkg
// Shared types and constants of the ordered record queue: field widths,
// command, status and register codes, and the stored record layout.
// ----------------------------------------------------------------------------
package orq_pkg;

    // default queue depth
    localparam int DEPTH_DEF = 16;

    // field widths
    localparam int CMD_W   = 3;
    localparam int ID_W    = 16;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int ART_IN_W = 8;
    localparam int ART_W   = 4;
    localparam int AMT_W   = 24;
    localparam int QCNT_W  = 5;
    localparam int STAT_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 112;

    // commands
    localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE_OLD = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE_ID  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LIST       = 3'd3;
    localparam logic [CMD_W-1:0] CMD_AVERAGE    = 3'd4;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] ST_INVALID   = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DAY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MONTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_YEAR  = 2'd2;

    // reset values of the working date
    localparam logic [DAY_W-1:0]   DAY_RST   = 5'd1;
    localparam logic [MONTH_W-1:0] MONTH_RST = 4'd1;
    localparam logic [YEAR_W-1:0]  YEAR_RST  = 14'd2000;

    // article count limits
    localparam logic [ART_IN_W-1:0] MIN_ARTICLES = 8'd1;
    localparam logic [ART_IN_W-1:0] MAX_ARTICLES = 8'd10;

    // stored record, id in the lowest bits
    typedef struct packed {
        logic [AMT_W-1:0]   amount;
        logic [ART_W-1:0]   articles;
        logic [MIN_W-1:0]   minute;
        logic [HOUR_W-1:0]  hour;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [ID_W-1:0]    id;
    } rec_t;

endpackage

@@ rtl/orq_store.sv @@
// ----------------------------------------------------------------------------
// orq_store
// Record memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module orq_store #(
    parameter int DEPTH = orq_pkg::DEPTH_DEF,
    parameter int IDX_W = 4
) (
    input  logic               clk,
    input  logic               we,
    input  logic [IDX_W-1:0]   waddr,
    input  orq_pkg::rec_t      wdata,
    input  logic               re,
    input  logic [IDX_W-1:0]   raddr,
    output orq_pkg::rec_t      rdata
);

    orq_pkg::rec_t mem [DEPTH];
    orq_pkg::rec_t rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/orq_div.sv @@
// ----------------------------------------------------------------------------
// orq_div
// Restoring divider, one quotient bit per cycle. done stays high and the
// quotient holds until the next start.
// ----------------------------------------------------------------------------
module orq_div #(
    parameter int DVD_W = 28,
    parameter int DVS_W = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CW = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;

    // one shift-subtract step
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DVD_W-1]};
        diff      = trial - {1'b0, divisor};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CW'(DVD_W - 1);
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = diff[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/ordered_record_queue_delete_by_id_unit.sv @@
// ----------------------------------------------------------------------------
// ordered_record_queue_delete_by_id_unit
// Ordered booking queue with insert, remove oldest, remove by id, list and
// average. A small sequencer walks the record memory one entry per step.
// ----------------------------------------------------------------------------
// Insert, rejects, empty answers: decided in S_DISP, registered as the result.
// Remove (oldest or by id): each entry searched passes S_SRD and S_SCHK, each
//   entry moved up passes S_MRD and S_MWR (compaction through the one read port
//   and the one write port). List: S_LRD and S_LOUT per record. Average: waits
//   in S_DIV on the one-bit-per-cycle divider.
// One word in flight; s_tready is high again from the edge that registers
// the last result. Reset (rst_n, async) empties the queue, sets next id to 1.
// ----------------------------------------------------------------------------
module ordered_record_queue_delete_by_id_unit #(
    parameter int QUEUE_DEPTH = orq_pkg::DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input words
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // target_id[15:0], hour[20:16], minute[26:21], articles[34:27],
    // amount_cents[58:35], zero fill
    input  logic [orq_pkg::S_DATA_W-1:0]    s_tdata,
    // command
    input  logic [orq_pkg::CMD_W-1:0]       s_tuser,
    // result words
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // entry_id[15:0], entry_day[20:16], entry_month[24:21], entry_year[38:25],
    // entry_hour[43:39], entry_minute[49:44], entry_articles[53:50],
    // entry_amount[77:54], queue_count[82:78], average_amount[106:83], zero fill
    output logic [orq_pkg::M_DATA_W-1:0]    m_tdata,
    // status
    output logic [orq_pkg::STAT_W-1:0]      m_tuser,
    output logic                            m_tlast,
    // configuration writes
    input  logic                            cfg_we,
    input  logic [orq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [orq_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int TOT_W = orq_pkg::AMT_W + ((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 0);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_DISP = 10'b00_0000_0010,
        S_SRD  = 10'b00_0000_0100,
        S_SCHK = 10'b00_0000_1000,
        S_MRD  = 10'b00_0001_0000,
        S_MWR  = 10'b00_0010_0000,
        S_FIN  = 10'b00_0100_0000,
        S_LRD  = 10'b00_1000_0000,
        S_LOUT = 10'b01_0000_0000,
        S_DIV  = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // latched input word
    logic [orq_pkg::CMD_W-1:0]    cmd_reg;
    logic [orq_pkg::ID_W-1:0]     target_reg;
    logic [orq_pkg::HOUR_W-1:0]   hour_reg;
    logic [orq_pkg::MIN_W-1:0]    minute_reg;
    logic [orq_pkg::ART_IN_W-1:0] articles_reg;
    logic [orq_pkg::AMT_W-1:0]    amount_reg;

    // queue state
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [CNT_W-1:0]           idx_reg, idx_next;
    logic [orq_pkg::ID_W-1:0]   next_id_reg, next_id_next;
    logic [TOT_W-1:0]           total_reg, total_next;
    orq_pkg::rec_t              hold_reg, hold_next;

    // working date
    logic [orq_pkg::DAY_W-1:0]   day_reg;
    logic [orq_pkg::MONTH_W-1:0] month_reg;
    logic [orq_pkg::YEAR_W-1:0]  year_reg;

    // output register
    logic                         m_valid_reg;
    orq_pkg::rec_t                out_rec_reg;
    logic [orq_pkg::STAT_W-1:0]   out_status_reg;
    logic [orq_pkg::QCNT_W-1:0]   out_qcnt_reg;
    logic [orq_pkg::AMT_W-1:0]    out_avg_reg;
    logic                         out_last_reg;

    // result being produced this cycle
    logic                         emit;
    logic [orq_pkg::STAT_W-1:0]   emit_status;
    orq_pkg::rec_t                emit_rec;
    logic [CNT_W-1:0]             emit_qcnt;
    logic [orq_pkg::AMT_W-1:0]    emit_avg;
    logic                         emit_last;

    // memory and divider hookup
    logic            mem_we, mem_re;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;
    orq_pkg::rec_t   mem_wdata, mem_rdata;
    logic            div_start, div_done;
    logic [TOT_W-1:0] div_q;

    logic             accept;
    logic             slot_free;
    logic             queue_empty;
    logic             queue_full;
    logic             bad_insert;
    logic [CNT_W:0]   idx_inc;
    orq_pkg::rec_t    new_rec;

    assign accept      = s_tvalid && s_tready;
    assign s_tready    = (state_reg == S_IDLE);
    assign slot_free   = !m_valid_reg || m_tready;
    assign queue_empty = (count_reg == '0);
    assign queue_full  = (count_reg == DEPTH_C);
    assign idx_inc     = {1'b0, idx_reg} + 1'b1;
    assign bad_insert  = (articles_reg < orq_pkg::MIN_ARTICLES)
                      || (articles_reg > orq_pkg::MAX_ARTICLES)
                      || (amount_reg == '0);

    // record built by an insert
    always_comb
    begin
        new_rec          = '0;
        new_rec.id       = next_id_reg;
        new_rec.day      = day_reg;
        new_rec.month    = month_reg;
        new_rec.year     = year_reg;
        new_rec.hour     = hour_reg;
        new_rec.minute   = minute_reg;
        new_rec.articles = articles_reg[orq_pkg::ART_W-1:0];
        new_rec.amount   = amount_reg;
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        next_id_next = next_id_reg;
        total_next   = total_reg;
        hold_next    = hold_reg;
        emit         = 1'b0;
        emit_status  = orq_pkg::ST_OK;
        emit_rec     = '0;
        emit_qcnt    = count_reg;
        emit_avg     = '0;
        emit_last    = 1'b1;
        mem_we       = 1'b0;
        mem_waddr    = idx_reg[IDX_W-1:0];
        mem_wdata    = mem_rdata;
        mem_re       = 1'b0;
        mem_raddr    = idx_reg[IDX_W-1:0];
        div_start    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DISP;
                end
            end

            S_DISP:
            begin
                case (cmd_reg)
                    orq_pkg::CMD_INSERT:
                    begin
                        if (slot_free)
                        begin
                            emit       = 1'b1;
                            state_next = S_IDLE;
                            if (bad_insert)
                            begin
                                emit_status = orq_pkg::ST_INVALID;
                            end
                            else if (queue_full)
                            begin
                                emit_status = orq_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we       = 1'b1;
                                mem_waddr    = count_reg[IDX_W-1:0];
                                mem_wdata    = new_rec;
                                count_next   = count_reg + 1'b1;
                                total_next   = total_reg + TOT_W'(amount_reg);
                                next_id_next = next_id_reg + 1'b1;
                                emit_rec     = new_rec;
                                emit_qcnt    = count_reg + 1'b1;
                            end
                        end
                    end

                    orq_pkg::CMD_REMOVE_OLD,
                    orq_pkg::CMD_REMOVE_ID:
                    begin
                        if (!queue_empty)
                        begin
                            idx_next   = '0;
                            state_next = S_SRD;
                        end
                        else if (slot_free)
                        begin
                            emit        = 1'b1;
                            emit_status = orq_pkg::ST_EMPTY;
                            state_next  = S_IDLE;
                        end
                    end

                    orq_pkg::CMD_LIST:
                    begin
                        if (!queue_empty)
                        begin
                            idx_next   = '0;
                            state_next = S_LRD;
                        end
                        else if (slot_free)
                        begin
                            emit        = 1'b1;
                            emit_status = orq_pkg::ST_EMPTY;
                            state_next  = S_IDLE;
                        end
                    end

                    orq_pkg::CMD_AVERAGE:
                    begin
                        if (!queue_empty)
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                        else if (slot_free)
                        begin
                            emit       = 1'b1;
                            state_next = S_IDLE;
                        end
                    end

                    default:
                    begin
                        if (slot_free)
                        begin
                            emit        = 1'b1;
                            emit_status = orq_pkg::ST_INVALID;
                            state_next  = S_IDLE;
                        end
                    end
                endcase
            end

            // search: read entry idx
            S_SRD:
            begin
                mem_re     = 1'b1;
                state_next = S_SCHK;
            end

            // search: compare entry idx
            S_SCHK:
            begin
                if ((cmd_reg == orq_pkg::CMD_REMOVE_OLD) || (mem_rdata.id == target_reg))
                begin
                    hold_next  = mem_rdata;
                    total_next = total_reg - TOT_W'(mem_rdata.amount);
                    state_next = S_MRD;
                end
                else if (idx_inc == {1'b0, count_reg})
                begin
                    if (slot_free)
                    begin
                        emit        = 1'b1;
                        emit_status = orq_pkg::ST_NOT_FOUND;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    idx_next   = idx_inc[CNT_W-1:0];
                    state_next = S_SRD;
                end
            end

            // compaction: read the entry behind the gap
            S_MRD:
            begin
                if (idx_inc < {1'b0, count_reg})
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = idx_inc[IDX_W-1:0];
                    state_next = S_MWR;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            // compaction: move it one place forward
            S_MWR:
            begin
                mem_we     = 1'b1;
                idx_next   = idx_inc[CNT_W-1:0];
                state_next = S_MRD;
            end

            S_FIN:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_rec   = hold_reg;
                    emit_qcnt  = count_reg - 1'b1;
                    count_next = count_reg - 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_LRD:
            begin
                mem_re     = 1'b1;
                state_next = S_LOUT;
            end

            S_LOUT:
            begin
                if (slot_free)
                begin
                    emit      = 1'b1;
                    emit_rec  = mem_rdata;
                    emit_last = (idx_inc == {1'b0, count_reg});
                    if (emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_inc[CNT_W-1:0];
                        state_next = S_LRD;
                    end
                end
            end

            S_DIV:
            begin
                if (div_done && slot_free)
                begin
                    emit       = 1'b1;
                    emit_avg   = div_q[orq_pkg::AMT_W-1:0];
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and queue state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            next_id_reg <= orq_pkg::ID_W'(1);
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            next_id_reg <= next_id_next;
            total_reg   <= total_next;
            if (emit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // working date registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            day_reg   <= orq_pkg::DAY_RST;
            month_reg <= orq_pkg::MONTH_RST;
            year_reg  <= orq_pkg::YEAR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                orq_pkg::CFG_DAY:   day_reg   <= cfg_data[orq_pkg::DAY_W-1:0];
                orq_pkg::CFG_MONTH: month_reg <= cfg_data[orq_pkg::MONTH_W-1:0];
                orq_pkg::CFG_YEAR:  year_reg  <= cfg_data[orq_pkg::YEAR_W-1:0];
                default:            ;
            endcase
        end
    end

    // input word latch
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg      <= s_tuser;
            target_reg   <= s_tdata[15:0];
            hour_reg     <= s_tdata[20:16];
            minute_reg   <= s_tdata[26:21];
            articles_reg <= s_tdata[34:27];
            amount_reg   <= s_tdata[58:35];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        if (emit)
        begin
            out_rec_reg    <= emit_rec;
            out_status_reg <= emit_status;
            out_qcnt_reg   <= orq_pkg::QCNT_W'(emit_qcnt);
            out_avg_reg    <= emit_avg;
            out_last_reg   <= emit_last;
        end
    end

    orq_store #(
        .DEPTH (QUEUE_DEPTH),
        .IDX_W (IDX_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    orq_div #(
        .DVD_W (TOT_W),
        .DVS_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (total_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'b0, out_avg_reg, out_qcnt_reg, out_rec_reg};

endmodule

@@ rtl/orq_checker.sv @@
// ----------------------------------------------------------------------------
// orq_checker
// Port-level checks of the ordered record queue, bound to the top level.
// ----------------------------------------------------------------------------
module orq_checker #(
    parameter int QUEUE_DEPTH = orq_pkg::DEPTH_DEF
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [orq_pkg::M_DATA_W-1:0]    m_tdata,
    input logic [orq_pkg::STAT_W-1:0]      m_tuser,
    input logic                            m_tlast
);

    // a failed command answers with a single word
    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != orq_pkg::ST_OK) |-> m_tlast)
        else $error("error status without last");

    // a failed command carries no record
    a_error_no_record: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != orq_pkg::ST_OK) |-> (m_tdata[77:0] == '0))
        else $error("error status with record fields");

    // reported fill level never exceeds the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (int'(m_tdata[82:78]) <= QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

endmodule

bind ordered_record_queue_delete_by_id_unit orq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_orq_checker (.*);
